// ===== rtl/core/block_allocator_bump_freelist_defines.svh =====
// Assertion macros for the block allocator checker.
`ifndef BLOCK_ALLOCATOR_BUMP_FREELIST_DEFINES_SVH
`define BLOCK_ALLOCATOR_BUMP_FREELIST_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define BAFL_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define BAFL_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/core/bafl_pkg.sv =====
// Constants and codes for the block allocator with bump pointer and free list.
package bafl_pkg;

    localparam int unsigned TOTAL_BLOCKS = 1023;
    localparam int unsigned INODE_BLOCKS = 64;
    localparam int unsigned BUMP_LIMIT   = 1023;

    localparam int unsigned IDX_W      = 10;
    localparam int unsigned LINK_DEPTH = 1 << IDX_W;
    localparam int unsigned STATUS_W   = 2;

    // Stream widths, rounded up to whole bytes
    localparam int unsigned IN_TDATA_W  = ((IDX_W + 7) / 8) * 8;
    localparam int unsigned OUT_TDATA_W = ((STATUS_W + IDX_W + 7) / 8) * 8;

    localparam logic [IDX_W-1:0] BUMP_RESET = IDX_W'((INODE_BLOCKS + 1) % LINK_DEPTH);

    typedef logic [IDX_W-1:0] idx_t;

    typedef enum logic [0:0] {
        FUNC_ALLOC = 1'b0,
        FUNC_FREE  = 1'b1
    } func_t;

    typedef enum logic [STATUS_W-1:0] {
        STATUS_OK       = 2'd0,
        STATUS_NO_BLOCK = 2'd1,
        STATUS_RANGE    = 2'd2
    } status_t;

endpackage

// ===== rtl/core/bafl_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module bafl_ram #(
    parameter int unsigned WIDTH = 10,
    parameter int unsigned DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/core/block_allocator_bump_freelist.sv =====
// Top level of the block allocator: bump pointer, free-list head and link store.
//
// Each request passes through an accept cycle and an execute state: in the accept
// cycle the link store is read at the current free-list head, and in the execute
// state the result is formed, the bump pointer or head is updated and, on a push,
// the link is written. One request is in flight at a time, so a new request is
// taken only after the last has executed; the registered read of the link store
// sets that pace. A result waits in the output register while the next request
// is taken; that request holds in its execute state only until the waiting beat
// is taken. The link store needs no clearing pass after reset: a pop only ever
// reads links that a push wrote.
module block_allocator_bump_freelist (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    // [9:0] block_index, [15:10] zero
    input  logic [bafl_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
    // [0] func
    input  logic                             s_axis_tuser,
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // [1:0] status, [11:2] block_number, [15:12] zero
    output logic [bafl_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);

    import bafl_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_EXEC = 2'b10
    } state_t;

    state_t    state_reg, state_next;
    idx_t      bump_reg, bump_next;
    idx_t      head_reg, head_next;
    logic      out_valid_reg, out_valid_next;
    status_t   out_status_reg, out_status_next;
    idx_t      out_number_reg, out_number_next;
    func_t     req_func_reg;
    idx_t      req_idx_reg;

    logic      in_fire;
    logic      exec_fire;
    logic      at_limit;
    logic      out_of_range;
    logic      below_bump;
    idx_t      link_rdata;
    logic      link_we;
    idx_t      got;

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign in_fire       = s_axis_tvalid && s_axis_tready;
    assign exec_fire     = (state_reg == ST_EXEC) && (!out_valid_reg || m_axis_tready);

    // Link store: read at the head on accept, written on a push
    bafl_ram #(
        .WIDTH (IDX_W),
        .DEPTH (LINK_DEPTH)
    ) u_link_ram (
        .clk   (clk),
        .we    (link_we),
        .waddr (req_idx_reg),
        .wdata (head_reg),
        .re    (in_fire),
        .raddr (head_reg),
        .rdata (link_rdata)
    );

    // Decode the request against the current pointers
    assign at_limit     = (32'(bump_reg) == BUMP_LIMIT);
    assign out_of_range = (32'(req_idx_reg) <= INODE_BLOCKS) ||
                          (32'(req_idx_reg) > TOTAL_BLOCKS);
    assign below_bump   = (({1'b0, req_idx_reg} + (IDX_W + 1)'(1)) == {1'b0, bump_reg});
    assign got          = at_limit ? head_reg : bump_reg;
    assign link_we      = exec_fire && (req_func_reg == FUNC_FREE) &&
                          !out_of_range && !below_bump;

    // Update pointers and form the result beat
    always_comb
    begin
        state_next      = state_reg;
        bump_next       = bump_reg;
        head_next       = head_reg;
        out_valid_next  = out_valid_reg;
        out_status_next = out_status_reg;
        out_number_next = out_number_reg;

        if (out_valid_reg && m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                if (exec_fire)
                begin
                    state_next      = ST_IDLE;
                    out_valid_next  = 1'b1;
                    out_status_next = STATUS_OK;
                    out_number_next = '0;
                    if (req_func_reg == FUNC_ALLOC)
                    begin
                        if (at_limit && (head_reg == '0))
                        begin
                            out_status_next = STATUS_NO_BLOCK;
                        end
                        else
                        begin
                            if (at_limit)
                            begin
                                head_next = link_rdata;
                            end
                            else
                            begin
                                bump_next = bump_reg + IDX_W'(1);
                            end
                            if (got == '0)
                            begin
                                out_status_next = STATUS_NO_BLOCK;
                            end
                            else
                            begin
                                out_number_next = got;
                            end
                        end
                    end
                    else
                    begin
                        if (out_of_range)
                        begin
                            out_status_next = STATUS_RANGE;
                        end
                        else if (below_bump)
                        begin
                            bump_next = req_idx_reg;
                        end
                        else
                        begin
                            head_next = req_idx_reg;
                        end
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            bump_reg      <= BUMP_RESET;
            head_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            bump_reg      <= bump_next;
            head_reg      <= head_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload: capture the request, hold the result beat
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            req_func_reg <= func_t'(s_axis_tuser);
            req_idx_reg  <= s_axis_tdata[IDX_W-1:0];
        end
        out_status_reg <= out_status_next;
        out_number_reg <= out_number_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = OUT_TDATA_W'({out_number_reg, out_status_reg});

endmodule

// ===== rtl/core/bafl_checker.sv =====
// Port-level checks for the block allocator, bound to its top level.
`include "block_allocator_bump_freelist_defines.svh"

module bafl_checker (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_axis_tvalid,
    input  logic                             s_axis_tready,
    input  logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    input  logic [bafl_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);

    import bafl_pkg::*;

    logic    in_beat;
    logic    out_stall;
    logic    fail_beat;
    logic    status_known;
    status_t out_status;
    idx_t    out_number;

    assign in_beat      = s_axis_tvalid && s_axis_tready;
    assign out_stall    = m_axis_tvalid && !m_axis_tready;
    assign out_status   = status_t'(m_axis_tdata[STATUS_W-1:0]);
    assign out_number   = m_axis_tdata[STATUS_W+IDX_W-1:STATUS_W];
    assign fail_beat    = m_axis_tvalid && (out_status != STATUS_OK);
    assign status_known = (out_status == STATUS_OK) || (out_status == STATUS_NO_BLOCK) ||
                          (out_status == STATUS_RANGE);

    // A stalled result beat stays valid
    `BAFL_ASSERT_NEXT(a_out_hold, out_stall, m_axis_tvalid, "stalled beat dropped")

    // A stalled result beat keeps its data
    `BAFL_ASSERT_NEXT(a_out_stable, out_stall, $stable(m_axis_tdata), "stalled beat changed")

    // One request in flight: no accept right after an accept
    `BAFL_ASSERT_NEXT(a_one_in_flight, in_beat, !s_axis_tready, "second request accepted")

    // Status is one of the defined codes
    `BAFL_ASSERT_NOW(a_status_code, m_axis_tvalid, status_known, "undefined status code")

    // A failed request carries no block number
    `BAFL_ASSERT_NOW(a_fail_zero, fail_beat, out_number == '0, "number set on failed request")

endmodule

bind block_allocator_bump_freelist bafl_checker u_bafl_checker (.*);
